// ----- sv/pulse_blink_output_bank_top_assert.svh -----
// Assertion macros for the output bank checker.
`ifndef PULSE_BLINK_OUTPUT_BANK_TOP_ASSERT_SVH
`define PULSE_BLINK_OUTPUT_BANK_TOP_ASSERT_SVH

// Property checked at every rising edge while out of reset.
`define PBO_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A signal holds its value in the cycle after a condition.
`define PBO_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

// ----- sv/pbo_pkg.sv -----
`default_nettype none

package pbo_pkg;

	localparam int NUM_OUTPUTS_DEF = 8;
	localparam int TIME_BITS_DEF   = 16;

	localparam int REQ_W    = 3;
	localparam int IDX_W    = 5;
	localparam int DUR_W    = 16;
	localparam int LEVELS_W = 8;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK    = 3'd0,
		REQ_SET     = 3'd1,
		REQ_PULSE   = 3'd2,
		REQ_BLINK   = 3'd3,
		REQ_TOGGLE  = 3'd4,
		REQ_ALL_OFF = 3'd5
	} req_type_t;

	// Decoded command; its strobes are qualified by transfer and by the reject check, blink and lvl are not.
	typedef struct packed {
		logic tick;
		logic all_off;
		logic set;
		logic toggle;
		logic load;
		logic blink;
		logic lvl;
	} pbo_cmd_t;

endpackage

`default_nettype wire

// ----- sv/pulse_blink_output_bank_top.sv -----
// Bank of pulse/blink output ports.
// Input channel (in_valid/in_stall) takes one request per transfer: tick,
// set, pulse, blink, toggle or all-off, with port_index, level and duration.
// Output channel (out_valid/out_stall) returns one result per request: the
// levels of ports 0 to 7 after the request and an ignored flag for a bad
// port index, a zero duration or an unknown request code.
// A request is taken into the input register; when it advances, it is applied
// to the port state and its result is registered in the output register, and
// a stalled output can hold it in the input register first.
// Throughput: one request per cycle unless the output stalls; a tick counts
// down every port, all-off clears all, others touch only the addressed port.
// When the receiver stalls, the result holds in the output register and one
// more request waits in the input register; in_stall rises only then.
// Reset clears every level, countdown and period and empties both registers.
`default_nettype none

module pulse_blink_output_bank_top #(
	parameter int NUM_OUTPUTS = pbo_pkg::NUM_OUTPUTS_DEF,
	parameter int TIME_BITS   = pbo_pkg::TIME_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [pbo_pkg::REQ_W-1:0]     req_type,
	input  wire logic [pbo_pkg::IDX_W-1:0]     port_index,
	input  wire logic                          level,
	input  wire logic [pbo_pkg::DUR_W-1:0]     duration,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [pbo_pkg::LEVELS_W-1:0]       out_levels,
	output logic                               ignored
);
	import pbo_pkg::*;

	localparam int DUR_USE = (TIME_BITS < DUR_W) ? TIME_BITS : DUR_W;

	logic                 valid_s1;
	logic [REQ_W-1:0]     req_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 lvl_s1;
	logic [DUR_W-1:0]     dur_s1;

	logic                 fire;
	logic [TIME_BITS-1:0] dur;
	logic                 idx_ok;
	logic                 dur_zero;
	logic                 rej;
	pbo_cmd_t             cmd;
	logic [NUM_OUTPUTS-1:0] lvl_nxt;
	logic [LEVELS_W-1:0]  levels_d;

	logic                 out_valid_q;
	logic [LEVELS_W-1:0]  levels_q;
	logic                 ignored_q;

	// advance the input register into the output register
	assign fire     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= req_type;
			idx_s1 <= port_index;
			lvl_s1 <= level;
			dur_s1 <= duration;
		end
	end

	assign dur      = TIME_BITS'(dur_s1[DUR_USE-1:0]);
	assign dur_zero = (dur == '0);
	assign idx_ok   = ((IDX_W + 1)'(idx_s1) < (IDX_W + 1)'(NUM_OUTPUTS));

	always_comb begin
		cmd = '0;
		rej = 1'b0;
		case (req_type_t'(req_s1))
			REQ_TICK: begin
				cmd.tick = fire;
			end
			REQ_ALL_OFF: begin
				cmd.all_off = fire;
			end
			REQ_SET: begin
				rej     = !idx_ok;
				cmd.set = fire && idx_ok;
			end
			REQ_TOGGLE: begin
				rej        = !idx_ok;
				cmd.toggle = fire && idx_ok;
			end
			REQ_PULSE: begin
				rej      = !idx_ok || dur_zero;
				cmd.load = fire && !rej;
			end
			REQ_BLINK: begin
				rej       = !idx_ok || dur_zero;
				cmd.load  = fire && !rej;
				cmd.blink = 1'b1;
			end
			default: begin
				rej = 1'b1;
			end
		endcase
		cmd.lvl = lvl_s1;
	end

	for (genvar i = 0; i < NUM_OUTPUTS; i++) begin : g_port
		pbo_port #(
			.TIME_BITS(TIME_BITS)
		) u_port (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.sel    (idx_s1 == IDX_W'(i)),
			.dur    (dur),
			.lvl_nxt(lvl_nxt[i])
		);
	end

	for (genvar b = 0; b < LEVELS_W; b++) begin : g_lvl
		if (b < NUM_OUTPUTS) begin : g_on
			assign levels_d[b] = lvl_nxt[b];
		end else begin : g_off
			assign levels_d[b] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			levels_q  <= levels_d;
			ignored_q <= rej;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_levels = levels_q;
	assign ignored    = ignored_q;

endmodule

`default_nettype wire

// ----- sv/pbo_port.sv -----
`default_nettype none

module pbo_port #(
	parameter int TIME_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pbo_pkg::pbo_cmd_t    cmd,
	input  wire logic                 sel,
	input  wire logic [TIME_BITS-1:0] dur,
	output logic                      lvl_nxt
);
	import pbo_pkg::*;

	logic                 lvl_q;
	logic [TIME_BITS-1:0] cnt_q;
	logic [TIME_BITS-1:0] per_q;
	logic                 lvl_d;
	logic [TIME_BITS-1:0] cnt_d;
	logic [TIME_BITS-1:0] per_d;

	always_comb begin
		lvl_d = lvl_q;
		cnt_d = cnt_q;
		per_d = per_q;
		if (cmd.all_off) begin
			lvl_d = 1'b0;
			cnt_d = '0;
			per_d = '0;
		end else if (cmd.tick) begin
			if (cnt_q != '0) begin
				// last tick of the interval: flip and reload
				if (cnt_q == TIME_BITS'(1)) begin
					lvl_d = ~lvl_q;
					cnt_d = per_q;
				end else begin
					cnt_d = cnt_q - TIME_BITS'(1);
				end
			end
		end else if (sel) begin
			if (cmd.set || cmd.toggle) begin
				lvl_d = cmd.set ? cmd.lvl : ~lvl_q;
				cnt_d = '0;
				per_d = '0;
			end else if (cmd.load) begin
				if (cnt_q == '0) begin
					lvl_d = ~lvl_q;
				end
				cnt_d = dur;
				per_d = cmd.blink ? dur : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= 1'b0;
			cnt_q <= '0;
			per_q <= '0;
		end else begin
			lvl_q <= lvl_d;
			cnt_q <= cnt_d;
			per_q <= per_d;
		end
	end

	assign lvl_nxt = lvl_d;

endmodule

`default_nettype wire

// ----- sv/pbo_checker.sv -----
`default_nettype none

module pbo_checker #(
	parameter int NUM_OUTPUTS = pbo_pkg::NUM_OUTPUTS_DEF
) (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic [pbo_pkg::LEVELS_W-1:0] out_levels,
	input wire logic                        ignored
);
	import pbo_pkg::*;

	`include "pulse_blink_output_bank_top_assert.svh"

	logic                in_held;
	logic                out_held;
	logic [LEVELS_W:0]   result_bits;
	logic [LEVELS_W-1:0] hi_levels;

	assign in_held     = in_valid && in_stall;
	assign out_held    = out_valid && out_stall;
	assign result_bits = {out_levels, ignored};
	assign hi_levels   = out_levels >> NUM_OUTPUTS;

	// stalled request stays offered
	`PBO_ASSERT(a_in_hold_valid, clk, arst_n, in_held |=> in_valid, "stalled input dropped")

	// stalled result stays offered and unchanged
	`PBO_ASSERT(a_out_hold_valid, clk, arst_n, out_held |=> out_valid, "stalled result dropped")
	`PBO_ASSERT_HOLD(a_out_hold_data, clk, arst_n, out_held, result_bits, "result changed")

	// back-pressure on the input only comes from a full, stalled output
	`PBO_ASSERT(a_in_stall_cause, clk, arst_n, in_stall |-> out_held, "stall not from output")

	// ports that do not exist never show as active
	`PBO_ASSERT(a_unused_levels, clk, arst_n, out_valid |-> hi_levels == '0, "missing port on")

endmodule

bind pulse_blink_output_bank_top pbo_checker #(
	.NUM_OUTPUTS(NUM_OUTPUTS)
) u_pbo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_levels(out_levels),
	.ignored   (ignored)
);

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import pbo_pkg::*;

	localparam int PORTS = NUM_OUTPUTS_DEF;
	localparam int RANDOM_ITEMS = 1200;
	localparam int QUIET_ITEMS = 150;
	localparam int LIMIT_CYCLES = 200000;
	localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd6;
	localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

	typedef struct {
		logic [LEVELS_W-1:0] levels;
		logic                ignored;
	} bank_result_t;

	// Tracks port levels, countdowns and periods; queues the levels each request should produce.
	class bank_scoreboard;
		bit                 port_on[PORTS];
		bit [DUR_W-1:0]     remaining[PORTS];
		bit [DUR_W-1:0]     reload[PORTS];
		bank_result_t       pending_results[$];
		int                 errors;

		function new();
			for (int p = 0; p < PORTS; p++) begin
				port_on[p] = 1'b0;
				remaining[p] = '0;
				reload[p] = '0;
			end
			errors = 0;
		endfunction

		function void note_request(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
				logic lvl, logic [DUR_W-1:0] dur);
			bank_result_t r;
			bit idx_ok;
			idx_ok = (idx < PORTS);
			r.ignored = 1'b0;
			case (req)
				REQ_TICK: begin
					for (int p = 0; p < PORTS; p++) begin
						if (remaining[p] != 0) begin
							remaining[p]--;
							// expire: flip and reload; a zero period ends the pulse
							if (remaining[p] == 0) begin
								port_on[p] = !port_on[p];
								remaining[p] = reload[p];
							end
						end
					end
				end
				REQ_SET, REQ_TOGGLE: begin
					if (!idx_ok) begin
						r.ignored = 1'b1;
					end else begin
						port_on[idx] = (req == REQ_SET) ? lvl : !port_on[idx];
						remaining[idx] = '0;
						reload[idx] = '0;
					end
				end
				REQ_PULSE, REQ_BLINK: begin
					if (!idx_ok || dur == 0) begin
						r.ignored = 1'b1;
					end else begin
						// a busy port keeps its level and just restarts the count
						if (remaining[idx] == 0)
							port_on[idx] = !port_on[idx];
						remaining[idx] = dur;
						reload[idx] = (req == REQ_BLINK) ? dur : '0;
					end
				end
				REQ_ALL_OFF: begin
					for (int p = 0; p < PORTS; p++) begin
						port_on[p] = 1'b0;
						remaining[p] = '0;
						reload[p] = '0;
					end
				end
				default: r.ignored = 1'b1;
			endcase
			r.levels = '0;
			for (int p = 0; p < PORTS && p < LEVELS_W; p++)
				r.levels[p] = port_on[p];
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [LEVELS_W-1:0] lv, logic ig);
			bank_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual levels %h ignored %b",
					$time, lv, ig);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (lv !== want.levels) begin
				$display("%0t: out_levels expected %h actual %h", $time, want.levels, lv);
				errors++;
			end
			if (ig !== want.ignored) begin
				$display("%0t: ignored expected %b actual %b", $time, want.ignored, ig);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [REQ_W-1:0]    req_type = '0;
	logic [IDX_W-1:0]    port_index = '0;
	logic                level = 1'b0;
	logic [DUR_W-1:0]    duration = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [LEVELS_W-1:0] out_levels;
	logic                ignored;

	bank_scoreboard sb = new();
	bit             quiet = 1'b0;
	int             cycles = 0;
	int             stall_left = 0;

	pulse_blink_output_bank_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.port_index (port_index),
		.level      (level),
		.duration   (duration),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_levels (out_levels),
		.ignored    (ignored)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: stall in random bursts until the quiet tail
	always @(negedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 9);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_result(out_levels, ignored);
	end

	// Called at a falling edge; returns at a falling edge after the transfer.
	task automatic send_request(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
			input logic lvl, input logic [DUR_W-1:0] dur);
		int gap;
		in_valid <= 1'b1;
		req_type <= req;
		port_index <= idx;
		level <= lvl;
		duration <= dur;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		sb.note_request(req, idx, lvl, dur);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic random_request();
		int pick;
		int dur_pick;
		logic [REQ_W-1:0] req;
		logic [IDX_W-1:0] idx;
		logic [DUR_W-1:0] dur;
		pick = $urandom_range(0, 99);
		dur_pick = $urandom_range(0, 19);
		if ($urandom_range(0, 9) == 0)
			idx = IDX_W'($urandom_range(PORTS, 31));
		else
			idx = IDX_W'($urandom_range(0, PORTS - 1));
		// mostly short durations so that countdowns expire between ticks
		if (dur_pick == 0)
			dur = '0;
		else if (dur_pick == 1)
			dur = DUR_W'($urandom);
		else
			dur = DUR_W'($urandom_range(1, 6));
		if (pick < 40)
			req = REQ_TICK;
		else if (pick < 55)
			req = REQ_PULSE;
		else if (pick < 70)
			req = REQ_BLINK;
		else if (pick < 80)
			req = REQ_SET;
		else if (pick < 88)
			req = REQ_TOGGLE;
		else if (pick < 92)
			req = REQ_ALL_OFF;
		else
			req = ($urandom_range(0, 1) == 0) ? REQ_UNUSED_LO : REQ_UNUSED_HI;
		send_request(req, idx, 1'($urandom_range(0, 1)), dur);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_request(REQ_TICK, 5'd0, 1'b0, 16'd0);
		send_request(REQ_SET, 5'd0, 1'b1, 16'd0);
		send_request(REQ_SET, 5'd7, 1'b1, 16'hFFFF);
		send_request(REQ_SET, 5'd8, 1'b1, 16'd0);
		send_request(REQ_SET, 5'd31, 1'b1, 16'd0);
		send_request(REQ_TOGGLE, 5'd3, 1'b0, 16'd0);
		send_request(REQ_TOGGLE, 5'd16, 1'b0, 16'd0);
		send_request(REQ_PULSE, 5'd1, 1'b0, 16'd2);
		send_request(REQ_TICK, 5'd0, 1'b0, 16'd0);
		send_request(REQ_TICK, 5'd0, 1'b0, 16'd0);
		send_request(REQ_BLINK, 5'd2, 1'b0, 16'd1);
		send_request(REQ_TICK, 5'd0, 1'b0, 16'd0);
		send_request(REQ_TICK, 5'd0, 1'b0, 16'd0);
		// restart on a busy port keeps its level
		send_request(REQ_PULSE, 5'd2, 1'b0, 16'd3);
		send_request(REQ_PULSE, 5'd4, 1'b0, 16'd0);
		send_request(REQ_BLINK, 5'd4, 1'b0, 16'd0);
		send_request(REQ_BLINK, 5'd12, 1'b1, 16'd5);
		send_request(REQ_PULSE, 5'd5, 1'b0, 16'hFFFF);
		send_request(REQ_BLINK, 5'd6, 1'b0, 16'h8000);
		send_request(REQ_TICK, 5'd0, 1'b0, 16'd0);
		send_request(REQ_UNUSED_LO, 5'd1, 1'b1, 16'd1);
		send_request(REQ_UNUSED_HI, 5'd31, 1'b1, 16'hFFFF);
		send_request(REQ_ALL_OFF, 5'd0, 1'b0, 16'd0);
		send_request(REQ_TOGGLE, 5'd7, 1'b1, 16'd0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - QUIET_ITEMS)
				quiet = 1'b1;
			random_request();
		end
		in_valid <= 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
